### sv/gatt_db_hash_cmac_unit_defines.svh
// Assertion macros for the GATT database hash unit
`ifndef GATT_DB_HASH_CMAC_UNIT_DEFINES_SVH
`define GATT_DB_HASH_CMAC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GDH_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("gdh implication failed");
`define GDH_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("gdh next-cycle check failed");
`else
`define GDH_ASSERT_IMPLY(label, clk, rst, a, b)
`define GDH_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### sv/gdh_pkg.sv
// Shared types, codes and AES helper functions for the GATT database hash unit
`default_nettype none
package gdh_pkg;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_VALUE  = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_PLAIN = 2'd1;
  localparam logic [1:0] CLS_VALUE = 2'd2;

  localparam logic [63:0] BASE_UUID_LOW  = 64'h80000080_5f9b34fb;
  localparam logic [31:0] BASE_UUID_MID  = 32'h0000_1000;

  typedef struct packed {
    logic busy;
    logic done;
  } gdh_aes_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte k of a block sits at bits 127-8k downto 120-8k.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
    return s[127-8*k -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [1:0] classify(input logic [15:0] t);
    logic [1:0] c;
    c = CLS_NONE;
    if (t >= 16'h2800 && t <= 16'h2803) c = CLS_VALUE;
    else if (t == 16'h2900) c = CLS_VALUE;
    else if (t >= 16'h2901 && t <= 16'h2905) c = CLS_PLAIN;
    return c;
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[127-8*(j+4*c) -: 8] = SBOX[get_byte(s, j + 4*((c + j) % 4))];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] t);
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, 4*c);
      a1 = get_byte(t, 4*c+1);
      a2 = get_byte(t, 4*c+2);
      a3 = get_byte(t, 4*c+3);
      m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return m;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w;
    logic [127:0] n;
    w = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
         SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
    n[127:96] = rk[127:96] ^ w;
    n[95:64]  = rk[95:64] ^ n[127:96];
    n[63:32]  = rk[63:32] ^ n[95:64];
    n[31:0]   = rk[31:0] ^ n[63:32];
    return n;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

endpackage
`default_nettype wire

### sv/gdh_if.sv
// Channel interfaces: attribute item input and hash result output
`default_nettype none
interface gdh_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] handle;
  logic        char_val;
  logic        uuid_is_long;
  logic [63:0] uuid_low;
  logic [63:0] uuid_high;
  logic [7:0]  value_byte;
  modport source (output valid, op, handle, char_val, uuid_is_long, uuid_low,
                  uuid_high, value_byte, input ready);
  modport sink (input valid, op, handle, char_val, uuid_is_long, uuid_low,
                uuid_high, value_byte, output ready);
endinterface

interface gdh_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_low;
  logic [63:0] hash_high;
  modport source (output valid, hash_low, hash_high, input ready);
  modport sink (input valid, hash_low, hash_high, output ready);
endinterface
`default_nettype wire

### sv/gatt_db_hash_cmac_unit.sv
// GATT database hash unit top level: byte-serial message feed, CMAC finish, result register
// One item at a time. A header that counts feeds 4 or 18 bytes, one per cycle except while
// the AES unit runs, into the pending block; a value byte feeds one. Each time a full block
// must make room, the shared AES round unit encrypts it. The end marker runs the subkey
// encryption, pads a partial last block, encrypts the last block and registers the MAC. The
// input is ready only when the unit is idle; a finished hash waits in the output register
// while the next item is accepted.
`default_nettype none
`include "gatt_db_hash_cmac_unit_defines.svh"
module gatt_db_hash_cmac_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  gdh_item_if.sink   in_ch,
  gdh_hash_if.source out_ch
);
  import gdh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FEED = 3'd1;
  localparam logic [2:0] ST_FAES = 3'd2;
  localparam logic [2:0] ST_LGEN = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_LAES = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [127:0]  chain;
  logic [127:0]  pend;
  logic [4:0]    cnt;
  logic          value_wanted;
  logic [143:0]  hb;
  logic [4:0]    hn;
  logic          use_k2;
  logic          pad_first;
  logic [127:0]  kreg;

  logic          accept;
  logic          end_accept;
  logic          aes_start;
  logic [127:0]  aes_blk;
  logic [127:0]  aes_res;
  gdh_aes_stat_t aes_stat;
  logic          out_free;

  logic [15:0]   short_t;
  logic [15:0]   long_t;
  logic          base_ok;
  logic [1:0]    cls;
  logic          hdr_ok;
  logic [143:0]  hdr_bytes;
  logic [127:0]  k1;

  assign accept   = in_ch.valid && in_ch.ready;
  assign end_accept = accept && (in_ch.op == OP_END);
  assign in_ch.ready = (state == ST_IDLE);
  assign out_free = !out_ch.valid || out_ch.ready;

  assign short_t = in_ch.uuid_low[15:0];
  assign long_t  = in_ch.uuid_high[47:32];
  assign base_ok = (in_ch.uuid_low == BASE_UUID_LOW) &&
                   (in_ch.uuid_high[31:0] == BASE_UUID_MID) &&
                   (in_ch.uuid_high[63:48] == 16'h0000);
  assign cls     = in_ch.uuid_is_long ? (base_ok ? classify(long_t) : CLS_NONE)
                                      : classify(short_t);
  assign hdr_ok  = !in_ch.char_val && (cls != CLS_NONE);

  always_comb begin
    hdr_bytes = '0;
    hdr_bytes[143:136] = in_ch.handle[7:0];
    hdr_bytes[135:128] = in_ch.handle[15:8];
    if (in_ch.uuid_is_long) begin
      for (int i = 0; i < 8; i++) begin
        hdr_bytes[127-8*i -: 8] = in_ch.uuid_low[8*i +: 8];
        hdr_bytes[63-8*i -: 8]  = in_ch.uuid_high[8*i +: 8];
      end
    end else begin
      hdr_bytes[127:120] = short_t[7:0];
      hdr_bytes[119:112] = short_t[15:8];
    end
  end

  assign k1 = dbl(aes_res);

  always_comb begin
    aes_start = 1'b0;
    aes_blk   = chain ^ pend;
    unique case (state)
      ST_IDLE: begin
        aes_blk   = '0;
        aes_start = end_accept;
      end
      ST_FEED: aes_start = (cnt == 5'd16) && (hn != 5'd0);
      ST_PAD: begin
        aes_blk   = chain ^ pend ^ kreg;
        aes_start = (cnt == 5'd16);
      end
      default: aes_start = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            OP_HEADER: if (hdr_ok) state_next = ST_FEED;
            OP_VALUE:  if (value_wanted) state_next = ST_FEED;
            OP_END:    state_next = ST_LGEN;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FEED: begin
        if (aes_start) state_next = ST_FAES;
        else if (hn == 5'd0) state_next = ST_IDLE;
      end
      ST_FAES: if (aes_stat.done) state_next = ST_FEED;
      ST_LGEN: if (aes_stat.done) state_next = ST_PAD;
      ST_PAD:  if (aes_start) state_next = ST_LAES;
      ST_LAES: if (aes_stat.done) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chain        <= '0;
      cnt          <= 5'd0;
      value_wanted <= 1'b0;
      hn           <= 5'd0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && in_ch.op == OP_HEADER) begin
            value_wanted <= hdr_ok && (cls == CLS_VALUE);
            hn <= in_ch.uuid_is_long ? 5'd18 : 5'd4;
          end else if (accept && in_ch.op == OP_VALUE) begin
            hn <= 5'd1;
          end
        end
        ST_FEED: begin
          if (aes_start) cnt <= 5'd0;
          else if (hn != 5'd0) begin
            cnt <= cnt + 5'd1;
            hn  <= hn - 5'd1;
          end
        end
        ST_FAES: if (aes_stat.done) chain <= aes_res;
        ST_PAD:  if (cnt != 5'd16) cnt <= cnt + 5'd1;
        ST_OUT: begin
          if (out_free) begin
            chain        <= '0;
            cnt          <= 5'd0;
            value_wanted <= 1'b0;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      hb        <= (in_ch.op == OP_VALUE) ? {in_ch.value_byte, 136'h0} : hdr_bytes;
      use_k2    <= (cnt != 5'd16);
      pad_first <= 1'b1;
    end
    if (state == ST_FEED && !aes_start && hn != 5'd0) begin
      pend <= {pend[119:0], hb[143:136]};
      hb   <= {hb[135:0], 8'h00};
    end
    if (state == ST_LGEN && aes_stat.done) kreg <= use_k2 ? dbl(k1) : k1;
    if (state == ST_PAD && cnt != 5'd16) begin
      pend      <= {pend[119:0], pad_first ? 8'h80 : 8'h00};
      pad_first <= 1'b0;
    end
    if (state == ST_OUT && out_free) begin
      for (int i = 0; i < 8; i++) begin
        out_ch.hash_low[8*i +: 8]  <= get_byte(aes_res, i);
        out_ch.hash_high[8*i +: 8] <= get_byte(aes_res, i + 8);
      end
    end
  end

  gdh_aes u_aes (
    .clk    (clk),
    .rst    (rst),
    .start  (aes_start),
    .blk    (aes_blk),
    .stat   (aes_stat),
    .result (aes_res)
  );

  `GDH_ASSERT_IMPLY(a_cnt_range, clk, rst, 1'b1, cnt <= 5'd16)
  `GDH_ASSERT_IMPLY(a_start_idle_unit, clk, rst, aes_start, !aes_stat.busy)
  `GDH_ASSERT_NEXT(a_end_starts_subkey, clk, rst, end_accept, state == ST_LGEN && aes_stat.busy)
endmodule
`default_nettype wire

### sv/gdh_aes.sv
// AES-128 encryption under the all-zero key, one round per cycle, round keys on the fly
`default_nettype none
module gdh_aes (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [127:0]          blk,
  output gdh_pkg::gdh_aes_stat_t     stat,
  output logic [127:0]               result
);
  import gdh_pkg::*;

  logic [127:0] s;
  logic [127:0] rk;
  logic [127:0] rk_next;
  logic [127:0] ss;
  logic [7:0]   rc;
  logic [3:0]   rnd;
  logic         busy;
  logic         done;

  assign rk_next = key_next(rk, rc);
  assign ss      = sub_shift(s);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= 4'd1;
      end else if (busy) begin
        rnd <= rnd + 4'd1;
        if (rnd == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s  <= blk;
      rk <= '0;
      rc <= 8'h01;
    end else if (busy) begin
      s  <= ((rnd == 4'd10) ? ss : mix(ss)) ^ rk_next;
      rk <= rk_next;
      rc <= xt(rc);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = s;
endmodule
`default_nettype wire
